// ===== hw/rtl/sgfb_pkg.sv =====
// Package for the scaled glyph frame blitter.
// Holds the command and state types, the coordinate type and the 5x7 glyph ROM.
// Depends on nothing.
`timescale 1ns / 1ps

package sgfb_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_RECT  = 2'd1,
        KIND_CHAR  = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_GLYPH,
        ST_READ
    } t_state;

    typedef logic signed [11:0] t_coord;

    localparam int GLYPH_ROWS = 7;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

    typedef logic [GLYPH_BITS-1:0] t_glyph;

    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_DASH  = 8'h2d;
    localparam logic [7:0] CODE_0     = 8'h30;
    localparam logic [7:0] CODE_1     = 8'h31;
    localparam logic [7:0] CODE_2     = 8'h32;
    localparam logic [7:0] CODE_3     = 8'h33;
    localparam logic [7:0] CODE_4     = 8'h34;
    localparam logic [7:0] CODE_5     = 8'h35;
    localparam logic [7:0] CODE_6     = 8'h36;
    localparam logic [7:0] CODE_7     = 8'h37;
    localparam logic [7:0] CODE_8     = 8'h38;
    localparam logic [7:0] CODE_9     = 8'h39;
    localparam logic [7:0] CODE_A     = 8'h41;
    localparam logic [7:0] CODE_B     = 8'h42;
    localparam logic [7:0] CODE_D     = 8'h44;
    localparam logic [7:0] CODE_I     = 8'h49;
    localparam logic [7:0] CODE_M     = 8'h4d;
    localparam logic [7:0] CODE_O     = 8'h4f;
    localparam logic [7:0] CODE_P     = 8'h50;
    localparam logic [7:0] CODE_R     = 8'h52;
    localparam logic [7:0] CODE_S     = 8'h53;
    localparam logic [7:0] CODE_T     = 8'h54;

    // Rows are packed top row first; within a row the leftmost column is the upper bit.
    function automatic t_glyph glyph_lookup(input logic [7:0] code);
        t_glyph bits;
        unique case (code)
            CODE_DASH: bits = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            CODE_0:    bits = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            CODE_1:    bits = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            CODE_2:    bits = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            CODE_3:    bits = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            CODE_4:    bits = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            CODE_5:    bits = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            CODE_6:    bits = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            CODE_7:    bits = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            CODE_8:    bits = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            CODE_9:    bits = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            CODE_A:    bits = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            CODE_B:    bits = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            CODE_D:    bits = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            CODE_I:    bits = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
            CODE_M:    bits = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            CODE_O:    bits = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            CODE_P:    bits = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            CODE_R:    bits = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            CODE_S:    bits = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            CODE_T:    bits = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            default:   bits = '0;
        endcase
        return bits;
    endfunction

endpackage

// ===== hw/rtl/scaled_glyph_frame_blitter_top.sv =====
// Top level of the scaled glyph frame blitter: frame store, pixel sequencer and result register.
// Depends on sgfb_pkg for the command and state types and the glyph ROM.
//
//   Channel   Handshake            Payload
//   command   i_valid / o_ready    i_kind, i_x_pos, i_y_pos, i_rect_width, i_rect_height,
//                                  i_glyph_code, i_glyph_scale, i_draw_color
//   result    o_valid / i_ready    o_pixel_color, o_pixel_in_frame
//
// The frame store takes one pixel write per cycle. A clear writes every pixel of the frame,
// a rectangle its clipped area, and a character walks its 35 glyph cells, filling the
// clipped square of each set one; a read fetches one pixel from the frame store.
// Empty clears and rectangles, and reads off the frame, finish in the cycle of acceptance.
// Reset clears only control state; the frame store holds no defined value until written.
// A new item is accepted while idle and while the result register is empty or being taken.
`timescale 1ns / 1ps

module scaled_glyph_frame_blitter_top
    import sgfb_pkg::*;
#(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 160
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [9:0]  i_x_pos,
    input  logic signed [9:0]  i_y_pos,
    input  logic [8:0]         i_rect_width,
    input  logic [8:0]         i_rect_height,
    input  logic [7:0]         i_glyph_code,
    input  logic [3:0]         i_glyph_scale,
    input  logic [15:0]        i_draw_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_pixel_color,
    output logic               o_pixel_in_frame
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(FRAME_WIDTH + 1);
    localparam int YW    = $clog2(FRAME_HEIGHT + 1);

    localparam t_coord          FW_C     = t_coord'(FRAME_WIDTH);
    localparam t_coord          FH_C     = t_coord'(FRAME_HEIGHT);
    localparam logic [AW-1:0]   FW_A     = AW'(FRAME_WIDTH);
    localparam logic [2:0]      LAST_COL = 3'(GLYPH_COLS - 1);
    localparam logic [2:0]      LAST_ROW = 3'(GLYPH_ROWS - 1);

    logic [15:0]   r_frame [DEPTH];
    logic [15:0]   r_rd_data;

    t_state        r_state, n_state;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_color, n_out_color;
    logic          r_out_in, n_out_in;

    logic [15:0]   r_color, n_color;
    logic          r_glyph_mode, n_glyph_mode;
    logic [XW-1:0] r_col, n_col;
    logic [XW-1:0] r_x0, n_x0;
    logic [XW-1:0] r_x1, n_x1;
    logic [YW-1:0] r_row, n_row;
    logic [YW-1:0] r_y1, n_y1;

    t_glyph        r_gbits, n_gbits;
    logic [2:0]    r_gc, n_gc;
    logic [2:0]    r_gr, n_gr;
    logic          r_gdone, n_gdone;
    t_coord        r_cx, n_cx;
    t_coord        r_cy, n_cy;
    t_coord        r_xbase, n_xbase;
    logic [3:0]    r_scale, n_scale;

    t_coord        box_x, box_y, box_w, box_h;
    t_coord        x_lo, y_lo, x_hi_s, y_hi_s, x_hi, y_hi;
    logic          box_empty;
    t_coord        scale_c;
    logic          accept;
    logic          in_frame;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          last_col, last_row;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_pixel_color    = r_out_color;
    assign o_pixel_in_frame = r_out_in;

    assign scale_c = t_coord'({1'b0, r_scale});

    always_comb begin
        if (r_state == ST_GLYPH) begin
            box_x = r_cx;
            box_y = r_cy;
            box_w = scale_c;
            box_h = scale_c;
        end else if (t_kind'(i_kind) == KIND_CLEAR) begin
            box_x = '0;
            box_y = '0;
            box_w = FW_C;
            box_h = FH_C;
        end else begin
            box_x = t_coord'(i_x_pos);
            box_y = t_coord'(i_y_pos);
            box_w = t_coord'({1'b0, i_rect_width});
            box_h = t_coord'({1'b0, i_rect_height});
        end
        x_lo      = (box_x < 0) ? t_coord'(0) : box_x;
        y_lo      = (box_y < 0) ? t_coord'(0) : box_y;
        x_hi_s    = box_x + box_w;
        y_hi_s    = box_y + box_h;
        x_hi      = (x_hi_s > FW_C) ? FW_C : x_hi_s;
        y_hi      = (y_hi_s > FH_C) ? FH_C : y_hi_s;
        box_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
    end

    assign in_frame = (i_x_pos >= 0) && (t_coord'(i_x_pos) < FW_C)
                   && (i_y_pos >= 0) && (t_coord'(i_y_pos) < FH_C);
    assign rd_addr  = AW'(i_y_pos[8:0]) * FW_A + AW'(i_x_pos[8:0]);
    assign wr_addr  = AW'(r_row) * FW_A + AW'(r_col);
    assign last_col = (r_col == XW'(r_x1 - XW'(1)));
    assign last_row = (r_row == YW'(r_y1 - YW'(1)));

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_color  = r_out_color;
        n_out_in     = r_out_in;
        n_color      = r_color;
        n_glyph_mode = r_glyph_mode;
        n_col        = r_col;
        n_x0         = r_x0;
        n_x1         = r_x1;
        n_row        = r_row;
        n_y1         = r_y1;
        n_gbits      = r_gbits;
        n_gc         = r_gc;
        n_gr         = r_gr;
        n_gdone      = r_gdone;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_xbase      = r_xbase;
        n_scale      = r_scale;
        rd_en        = 1'b0;
        wr_en        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_color = i_draw_color;
                    unique case (t_kind'(i_kind))
                        KIND_CLEAR, KIND_RECT: begin
                            if (box_empty) begin
                                n_out_valid = 1'b1;
                                n_out_color = '0;
                                n_out_in    = 1'b0;
                            end else begin
                                n_col        = XW'(x_lo);
                                n_x0         = XW'(x_lo);
                                n_x1         = XW'(x_hi);
                                n_row        = YW'(y_lo);
                                n_y1         = YW'(y_hi);
                                n_glyph_mode = 1'b0;
                                n_state      = ST_FILL;
                            end
                        end
                        KIND_CHAR: begin
                            n_gbits = glyph_lookup(i_glyph_code);
                            n_gc    = '0;
                            n_gr    = '0;
                            n_gdone = 1'b0;
                            n_cx    = t_coord'(i_x_pos);
                            n_cy    = t_coord'(i_y_pos);
                            n_xbase = t_coord'(i_x_pos);
                            n_scale = i_glyph_scale;
                            n_state = ST_GLYPH;
                        end
                        KIND_READ: begin
                            if (in_frame) begin
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_color = '0;
                                n_out_in    = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                wr_en = 1'b1;
                if (last_col) begin
                    n_col = r_x0;
                    if (last_row) begin
                        if (r_glyph_mode) begin
                            n_state = ST_GLYPH;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_color = '0;
                            n_out_in    = 1'b0;
                            n_state     = ST_IDLE;
                        end
                    end else begin
                        n_row = YW'(r_row + YW'(1));
                    end
                end else begin
                    n_col = XW'(r_col + XW'(1));
                end
            end
            ST_GLYPH: begin
                if (r_gdone) begin
                    n_out_valid = 1'b1;
                    n_out_color = '0;
                    n_out_in    = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    n_gbits = r_gbits << 1;
                    if (r_gc == LAST_COL) begin
                        n_gc = '0;
                        n_cx = r_xbase;
                        n_cy = r_cy + scale_c;
                        if (r_gr == LAST_ROW) begin
                            n_gdone = 1'b1;
                        end else begin
                            n_gr = r_gr + 3'd1;
                        end
                    end else begin
                        n_gc = r_gc + 3'd1;
                        n_cx = r_cx + scale_c;
                    end
                    if (r_gbits[GLYPH_BITS-1] && !box_empty) begin
                        n_col        = XW'(x_lo);
                        n_x0         = XW'(x_lo);
                        n_x1         = XW'(x_hi);
                        n_row        = YW'(y_lo);
                        n_y1         = YW'(y_hi);
                        n_glyph_mode = 1'b1;
                        n_state      = ST_FILL;
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_color = r_rd_data;
                n_out_in    = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_color  <= n_out_color;
        r_out_in     <= n_out_in;
        r_color      <= n_color;
        r_glyph_mode <= n_glyph_mode;
        r_col        <= n_col;
        r_x0         <= n_x0;
        r_x1         <= n_x1;
        r_row        <= n_row;
        r_y1         <= n_y1;
        r_gbits      <= n_gbits;
        r_gc         <= n_gc;
        r_gr         <= n_gr;
        r_gdone      <= n_gdone;
        r_cx         <= n_cx;
        r_cy         <= n_cy;
        r_xbase      <= n_xbase;
        r_scale      <= n_scale;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame[wr_addr] <= r_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_frame[rd_addr];
        end
    end

endmodule

// ===== tb/scaled_glyph_frame_blitter_top_tb.sv =====
// Self-checking testbench for the scaled glyph frame blitter top level.
// Mirrors the frame store in a scoreboard class, drives clears, fills, glyphs and reads.
// Depends on sgfb_pkg and scaled_glyph_frame_blitter_top.
`timescale 1ns / 1ps

module scaled_glyph_frame_blitter_top_tb;
    import sgfb_pkg::*;

    localparam int FRAME_W      = 128;
    localparam int FRAME_H      = 160;
    localparam int RANDOM_ITEMS = 900;

    localparam logic [7:0] ROM_CODES [22] = '{
        CODE_SPACE, CODE_DASH, CODE_0, CODE_1, CODE_2, CODE_3, CODE_4, CODE_5,
        CODE_6, CODE_7, CODE_8, CODE_9, CODE_A, CODE_B, CODE_D, CODE_I,
        CODE_M, CODE_O, CODE_P, CODE_R, CODE_S, CODE_T
    };

    typedef struct {
        t_kind              kind;
        logic signed [9:0]  x_pos;
        logic signed [9:0]  y_pos;
        logic [8:0]         rect_width;
        logic [8:0]         rect_height;
        logic [7:0]         glyph_code;
        logic [3:0]         glyph_scale;
        logic [15:0]        draw_color;
    } t_blit_cmd;

    typedef struct {
        logic [15:0] color;
        logic        in_frame;
    } t_pixel_result;

    class t_frame_mirror;
        logic [15:0]   pixels [FRAME_W*FRAME_H];
        t_glyph        font [logic [7:0]];
        t_pixel_result expected_pixels [$];
        int            failures;

        function new();
            failures        = 0;
            font[CODE_SPACE] = '0;
            font[CODE_DASH] = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            font[CODE_0]    = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            font[CODE_1]    = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            font[CODE_2]    = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            font[CODE_3]    = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            font[CODE_4]    = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            font[CODE_5]    = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            font[CODE_6]    = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            font[CODE_7]    = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            font[CODE_8]    = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            font[CODE_9]    = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            font[CODE_A]    = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            font[CODE_B]    = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            font[CODE_D]    = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            font[CODE_I]    = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
            font[CODE_M]    = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            font[CODE_O]    = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            font[CODE_P]    = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            font[CODE_R]    = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            font[CODE_S]    = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            font[CODE_T]    = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
        endfunction

        function void paint_box(int x, int y, int w, int h, logic [15:0] color);
            int x0, y0, x1, y1, r, c;
            x0 = (x < 0) ? 0 : x;
            y0 = (y < 0) ? 0 : y;
            x1 = (x + w > FRAME_W) ? FRAME_W : x + w;
            y1 = (y + h > FRAME_H) ? FRAME_H : y + h;
            for (r = y0; r < y1; r++) begin
                for (c = x0; c < x1; c++) begin
                    pixels[r*FRAME_W + c] = color;
                end
            end
        endfunction

        function void apply_command(t_blit_cmd cmd);
            t_pixel_result res;
            t_glyph        bits;
            int            x, y, s, r, c;
            x   = int'(cmd.x_pos);
            y   = int'(cmd.y_pos);
            s   = int'(cmd.glyph_scale);
            res = '{16'h0000, 1'b0};
            case (cmd.kind)
                KIND_CLEAR: begin
                    foreach (pixels[i]) pixels[i] = cmd.draw_color;
                end
                KIND_RECT: begin
                    paint_box(x, y, int'(cmd.rect_width), int'(cmd.rect_height),
                              cmd.draw_color);
                end
                KIND_CHAR: begin
                    bits = font.exists(cmd.glyph_code) ? font[cmd.glyph_code] : '0;
                    for (r = 0; r < GLYPH_ROWS; r++) begin
                        for (c = 0; c < GLYPH_COLS; c++) begin
                            if (bits[GLYPH_BITS - 1 - (r*GLYPH_COLS + c)]) begin
                                paint_box(x + c*s, y + r*s, s, s, cmd.draw_color);
                            end
                        end
                    end
                end
                default: begin
                    if (x >= 0 && x < FRAME_W && y >= 0 && y < FRAME_H) begin
                        res.color    = pixels[y*FRAME_W + x];
                        res.in_frame = 1'b1;
                    end
                end
            endcase
            expected_pixels.push_back(res);
        endfunction

        function void check_pixel_result(logic [15:0] color, logic in_frame);
            t_pixel_result want;
            if (expected_pixels.size() == 0) begin
                $error("result with no item waiting: pixel_color %h, pixel_in_frame %b",
                       color, in_frame);
                failures++;
            end else begin
                want = expected_pixels.pop_front();
                if (color !== want.color) begin
                    $error("pixel_color: expected %h, actual %h", want.color, color);
                    failures++;
                end
                if (in_frame !== want.in_frame) begin
                    $error("pixel_in_frame: expected %b, actual %b", want.in_frame, in_frame);
                    failures++;
                end
            end
        endfunction
    endclass

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_ready;
    logic [1:0]        i_kind           = '0;
    logic signed [9:0] i_x_pos          = '0;
    logic signed [9:0] i_y_pos          = '0;
    logic [8:0]        i_rect_width     = '0;
    logic [8:0]        i_rect_height    = '0;
    logic [7:0]        i_glyph_code     = '0;
    logic [3:0]        i_glyph_scale    = '0;
    logic [15:0]       i_draw_color     = '0;
    logic              o_valid;
    logic              i_ready          = 1'b0;
    logic [15:0]       o_pixel_color;
    logic              o_pixel_in_frame;

    t_frame_mirror board;
    bit          calm       = 1'b0;
    int          clears_left = 6;
    int          big_rects_left = 8;
    int          big_glyphs_left = 30;
    int          last_x = 0;
    int          last_y = 0;
    int          last_w = 0;
    int          last_h = 0;

    scaled_glyph_frame_blitter_top #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_x_pos          (i_x_pos),
        .i_y_pos          (i_y_pos),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_glyph_code     (i_glyph_code),
        .i_glyph_scale    (i_glyph_scale),
        .i_draw_color     (i_draw_color),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_color    (o_pixel_color),
        .o_pixel_in_frame (o_pixel_in_frame)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_blit_cmd make_cmd(t_kind kind, int x, int y, int w, int h,
                                           logic [7:0] code, int scale, logic [15:0] color);
        t_blit_cmd cmd;
        cmd.kind        = kind;
        cmd.x_pos       = 10'(x);
        cmd.y_pos       = 10'(y);
        cmd.rect_width  = 9'(w);
        cmd.rect_height = 9'(h);
        cmd.glyph_code  = code;
        cmd.glyph_scale = 4'(scale);
        cmd.draw_color  = color;
        return cmd;
    endfunction

    function automatic t_blit_cmd random_cmd();
        t_blit_cmd cmd;
        int        pick;
        int        roll;
        cmd = make_cmd(KIND_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 511), $urandom_range(0, 511),
                       8'($urandom_range(0, 255)), $urandom_range(0, 15),
                       16'($urandom_range(0, 65535)));
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        if (pick < 2 && clears_left > 0) begin
            cmd.kind = KIND_CLEAR;
            clears_left--;
        end else if (pick < 32) begin
            cmd.kind = KIND_RECT;
            if (roll < 4 && big_rects_left > 0) begin
                big_rects_left--;
            end else if (roll < 30) begin
                cmd.rect_width  = 9'($urandom_range(0, 63));
                cmd.rect_height = 9'($urandom_range(0, 63));
            end else begin
                cmd.rect_width  = 9'($urandom_range(0, 15));
                cmd.rect_height = 9'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 4) != 0) begin
                cmd.x_pos = 10'(int'($urandom_range(0, 159)) - 16);
                cmd.y_pos = 10'(int'($urandom_range(0, 191)) - 16);
            end
            last_w = int'(cmd.rect_width);
            last_h = int'(cmd.rect_height);
            last_x = int'(cmd.x_pos);
            last_y = int'(cmd.y_pos);
        end else if (pick < 57) begin
            cmd.kind = KIND_CHAR;
            if ($urandom_range(0, 99) < 65) begin
                cmd.glyph_code = ROM_CODES[$urandom_range(0, 21)];
            end
            if (roll < 12 && big_glyphs_left > 0) begin
                cmd.glyph_scale = 4'($urandom_range(4, 15));
                big_glyphs_left--;
            end else begin
                cmd.glyph_scale = 4'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 9) != 0) begin
                cmd.x_pos = 10'(int'($urandom_range(0, 143)) - 8);
                cmd.y_pos = 10'(int'($urandom_range(0, 175)) - 8);
            end
            last_w = 5 * int'(cmd.glyph_scale);
            last_h = 7 * int'(cmd.glyph_scale);
            last_x = int'(cmd.x_pos);
            last_y = int'(cmd.y_pos);
        end else begin
            if (roll < 60) begin
                cmd.x_pos = 10'(last_x + int'($urandom_range(0, last_w)));
                cmd.y_pos = 10'(last_y + int'($urandom_range(0, last_h)));
            end else if (roll < 90) begin
                cmd.x_pos = 10'($urandom_range(0, FRAME_W - 1));
                cmd.y_pos = 10'($urandom_range(0, FRAME_H - 1));
            end
        end
        return cmd;
    endfunction

    task automatic send_cmd(t_blit_cmd cmd);
        while (!calm && $urandom_range(0, 99) < 36) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= cmd.kind;
        i_x_pos       <= cmd.x_pos;
        i_y_pos       <= cmd.y_pos;
        i_rect_width  <= cmd.rect_width;
        i_rect_height <= cmd.rect_height;
        i_glyph_code  <= cmd.glyph_code;
        i_glyph_scale <= cmd.glyph_scale;
        i_draw_color  <= cmd.draw_color;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.apply_command(cmd);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_pixel_result(o_pixel_color, o_pixel_in_frame);
        end
    end

    initial begin
        #(64'd200_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_blit_cmd plan [$];
        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        plan.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 8'h00, 0, 16'hffff));
        plan.push_back(make_cmd(KIND_READ, 0, 0, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 127, 159, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, -1, 0, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 0, 160, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, -512, -512, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 511, 511, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_RECT, -5, -5, 10, 10, 8'h00, 0, 16'h1234));
        plan.push_back(make_cmd(KIND_RECT, 120, 150, 511, 511, 8'h00, 0, 16'h8001));
        plan.push_back(make_cmd(KIND_RECT, 10, 10, 0, 20, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_RECT, 10, 10, 20, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_RECT, -512, -512, 511, 511, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_RECT, 511, 511, 511, 511, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 4, 4, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 127, 159, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_CHAR, 10, 10, 0, 0, CODE_8, 1, 16'h00ff));
        plan.push_back(make_cmd(KIND_READ, 11, 10, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 10, 10, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_CHAR, -3, -3, 0, 0, CODE_0, 2, 16'h0f0f));
        plan.push_back(make_cmd(KIND_CHAR, 0, 0, 0, 0, 8'hff, 15, 16'h0000));
        plan.push_back(make_cmd(KIND_CHAR, 20, 20, 0, 0, CODE_M, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_CHAR, 100, 140, 0, 0, CODE_T, 15, 16'h0000));
        plan.push_back(make_cmd(KIND_CHAR, 30, 30, 0, 0, CODE_SPACE, 3, 16'h0000));
        plan.push_back(make_cmd(KIND_READ, 112, 140, 0, 0, 8'h00, 0, 16'h0000));
        plan.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 8'h00, 0, 16'h0000));
        foreach (plan[i]) send_cmd(plan[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 300 && n < 450);
            send_cmd(random_cmd());
        end
        calm    = 1'b0;
        i_valid <= 1'b0;

        while (board.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sgfb_pkg.sv
hw/rtl/scaled_glyph_frame_blitter_top.sv
tb/scaled_glyph_frame_blitter_top_tb.sv
